// File: design/dls_pkg.sv
package dls_pkg;

   // Default sizes of the task table and of the key masks
   localparam int MAX_TASKS_DEF = 16;
   localparam int KEY_BITS_DEF  = 64;

   // Fixed widths of the channel fields
   localparam int MASK_W      = 64;
   localparam int TASK_IDX_W  = 4;
   localparam int STATUS_W    = 2;
   localparam int LEVEL_W     = 4;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 4;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_SCHEDULED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EXCLUDED  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CYCLE     = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RESTRICT_ENABLE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_INDEX    = 1'd1;

   // Controller states
   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_ROW_START = 7'b0000010,
      ST_ROW_SCAN  = 7'b0000100,
      ST_CLOSE     = 7'b0001000,
      ST_PEEL      = 7'b0010000,
      ST_EMIT_READ = 7'b0100000,
      ST_EMIT_LOAD = 7'b1000000
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic start;
      logic row_start;
      logic scan;
      logic close;
      logic peel;
      logic emit_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic row_end;
      logic last_row;
      logic closure_stable;
      logic no_roots;
      logic last_emit;
      logic out_free;
   } stat_type;

endpackage

// File: design/dls_ram.sv
module dls_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write one word, read one word with a registered output
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/dls_ctrl.sv
module dls_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_last_task,
   output logic               req_stall,
   input  dls_pkg::stat_type  stat,
   output dls_pkg::cmd_type   cmd
);

   dls_pkg::state_type state_ff;
   dls_pkg::state_type state_in;

   // Sequence loading, row building, closure, level peeling and result output
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         dls_pkg::ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid && req_last_task) begin
               cmd.start = 1'b1;
               state_in  = dls_pkg::ST_ROW_START;
            end
         end
         dls_pkg::ST_ROW_START: begin
            cmd.row_start = 1'b1;
            state_in      = dls_pkg::ST_ROW_SCAN;
         end
         dls_pkg::ST_ROW_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.row_end) begin
               state_in = stat.last_row ? dls_pkg::ST_CLOSE : dls_pkg::ST_ROW_START;
            end
         end
         dls_pkg::ST_CLOSE: begin
            cmd.close = 1'b1;
            if (stat.closure_stable) begin
               state_in = dls_pkg::ST_PEEL;
            end
         end
         dls_pkg::ST_PEEL: begin
            cmd.peel = 1'b1;
            if (stat.no_roots) begin
               state_in = dls_pkg::ST_EMIT_READ;
            end
         end
         dls_pkg::ST_EMIT_READ: begin
            state_in = dls_pkg::ST_EMIT_LOAD;
         end
         dls_pkg::ST_EMIT_LOAD: begin
            if (stat.out_free) begin
               cmd.emit_load = 1'b1;
               state_in = stat.last_emit ? dls_pkg::ST_IDLE : dls_pkg::ST_EMIT_READ;
            end
         end
         default: begin
            state_in = dls_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dls_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Take descriptors only while idle
   assign req_stall = (state_ff != dls_pkg::ST_IDLE);

endmodule

// File: design/dls_datapath.sv
module dls_datapath #(
   parameter int MAX_TASKS = dls_pkg::MAX_TASKS_DEF,
   parameter int KEY_BITS  = dls_pkg::KEY_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dls_pkg::cmd_type                  cmd,
   output dls_pkg::stat_type                 stat,
   input  logic [dls_pkg::MASK_W-1:0]        req_need_mask,
   input  logic [dls_pkg::MASK_W-1:0]        req_provide_mask,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dls_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dls_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [dls_pkg::TASK_IDX_W-1:0]    rsp_task_index,
   output logic [dls_pkg::STATUS_W-1:0]      rsp_task_status,
   output logic [dls_pkg::LEVEL_W-1:0]       rsp_task_level,
   output logic [dls_pkg::MASK_W-1:0]        rsp_unresolved_keys,
   output logic                              rsp_last_result
);

   localparam int IDX_W = $clog2(MAX_TASKS);
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int CMP_W = (CNT_W > dls_pkg::TASK_IDX_W) ? CNT_W : dls_pkg::TASK_IDX_W;
   localparam logic [MAX_TASKS-1:0] ONE = {{(MAX_TASKS-1){1'b0}}, 1'b1};

   // Configuration
   logic                           restrict_ff;
   logic [dls_pkg::TASK_IDX_W-1:0] target_ff;

   // Counters and scan state
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     i_ff, i_in;
   logic [IDX_W-1:0]     j_ff, j_in;
   logic [IDX_W-1:0]     e_ff, e_in;
   logic                 first_ff, first_in;
   logic [KEY_BITS-1:0]  open_ff, open_in;
   logic [MAX_TASKS-1:0] row_ff, row_in;

   // Graph state
   logic [MAX_TASKS-1:0]         rows_ff  [MAX_TASKS];
   logic [dls_pkg::LEVEL_W-1:0]  level_ff [MAX_TASKS];
   logic [MAX_TASKS-1:0]         set_ff, set_in;
   logic [MAX_TASKS-1:0]         remaining_ff, remaining_in;
   logic [MAX_TASKS-1:0]         excluded_ff, excluded_in;
   logic [dls_pkg::LEVEL_W-1:0]  depth_ff, depth_in;

   // Result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [dls_pkg::TASK_IDX_W-1:0] rsp_index_ff;
   logic [dls_pkg::STATUS_W-1:0]   rsp_status_ff, status_now;
   logic [dls_pkg::LEVEL_W-1:0]    rsp_level_ff, level_now;
   logic [dls_pkg::MASK_W-1:0]     rsp_keys_ff;
   logic                           rsp_last_ff;

   // Memory ports
   logic                 store_we;
   logic [IDX_W-1:0]     prov_raddr;
   logic [KEY_BITS-1:0]  need_rdata, prov_rdata, unres_rdata;

   // Combinational terms
   logic [CNT_W-1:0]     last_idx;
   logic [KEY_BITS-1:0]  cur_open, got, open_next;
   logic [MAX_TASKS-1:0] row_next, all_mask, set_next, kept, roots;
   logic                 target_ok;

   // Descriptor stores and the per-task unresolved keys
   assign store_we   = cmd.load && (count_ff < CNT_W'(MAX_TASKS));
   assign prov_raddr = cmd.row_start ? '0 : IDX_W'(j_ff + 1'b1);

   dls_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_TASKS)) u_need_ram (
      .clock (clock),
      .we    (store_we),
      .waddr (count_ff[IDX_W-1:0]),
      .wdata (req_need_mask[KEY_BITS-1:0]),
      .raddr (i_ff),
      .rdata (need_rdata)
   );

   dls_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_TASKS)) u_prov_ram (
      .clock (clock),
      .we    (store_we),
      .waddr (count_ff[IDX_W-1:0]),
      .wdata (req_provide_mask[KEY_BITS-1:0]),
      .raddr (prov_raddr),
      .rdata (prov_rdata)
   );

   dls_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_TASKS)) u_unres_ram (
      .clock (clock),
      .we    (cmd.scan && stat.row_end),
      .waddr (i_ff),
      .wdata (open_next),
      .raddr (e_ff),
      .rdata (unres_rdata)
   );

   // Scan one provider per cycle against the open needed keys of row i
   always_comb begin
      last_idx  = count_ff - 1'b1;
      cur_open  = first_ff ? need_rdata : open_ff;
      got       = cur_open & prov_rdata;
      open_next = cur_open & ~got;
      row_next  = (|got) ? (row_ff | (ONE << j_ff)) : row_ff;
      target_ok = CMP_W'(target_ff) < CMP_W'(count_ff);
   end

   // Closure step, kept set and ready tasks of this round
   always_comb begin
      set_next = set_ff;
      for (int k = 0; k < MAX_TASKS; k++) begin
         all_mask[k] = CNT_W'(k) < count_ff;
         if (set_ff[k]) begin
            set_next = set_next | rows_ff[k];
         end
         roots[k] = remaining_ff[k] && ((rows_ff[k] & remaining_ff) == '0);
      end
      kept = restrict_ff ? (set_ff & all_mask) : all_mask;
   end

   // Status and level of the task being output
   always_comb begin
      priority if (excluded_ff[e_ff]) begin
         status_now = dls_pkg::STATUS_EXCLUDED;
      end else if (remaining_ff[e_ff]) begin
         status_now = dls_pkg::STATUS_CYCLE;
      end else begin
         status_now = dls_pkg::STATUS_SCHEDULED;
      end
      level_now = (status_now == dls_pkg::STATUS_SCHEDULED) ? level_ff[e_ff] : '0;
   end

   always_comb begin
      stat.row_end        = CNT_W'(j_ff) == last_idx;
      stat.last_row       = CNT_W'(i_ff) == last_idx;
      stat.closure_stable = set_next == set_ff;
      stat.no_roots       = roots == '0;
      stat.last_emit      = CNT_W'(e_ff) == last_idx;
      stat.out_free       = !rsp_valid_ff || !rsp_stall;
   end

   // Next values of counters and sets
   always_comb begin
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      e_in         = e_ff;
      first_in     = first_ff;
      open_in      = open_ff;
      row_in       = row_ff;
      set_in       = set_ff;
      remaining_in = remaining_ff;
      excluded_in  = excluded_ff;
      depth_in     = depth_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (store_we) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.start) begin
         i_in = '0;
      end
      if (cmd.row_start) begin
         j_in     = '0;
         first_in = 1'b1;
         row_in   = '0;
      end
      if (cmd.scan) begin
         first_in = 1'b0;
         open_in  = open_next;
         row_in   = row_next;
         j_in     = IDX_W'(j_ff + 1'b1);
         if (stat.row_end) begin
            i_in = IDX_W'(i_ff + 1'b1);
            if (stat.last_row) begin
               set_in = target_ok ? (ONE << target_ff) : '0;
            end
         end
      end
      if (cmd.close) begin
         set_in = set_next;
         if (stat.closure_stable) begin
            remaining_in = kept;
            excluded_in  = all_mask & ~kept;
            depth_in     = '0;
         end
      end
      if (cmd.peel) begin
         remaining_in = remaining_ff & ~roots;
         depth_in     = depth_ff + 1'b1;
         if (stat.no_roots) begin
            e_in = '0;
         end
      end
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
         e_in         = IDX_W'(e_ff + 1'b1);
         if (stat.last_emit) begin
            count_in = '0;
         end
      end
   end

   // Control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         restrict_ff  <= 1'b0;
         target_ff    <= '0;
         remaining_ff <= '0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         remaining_ff <= remaining_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               dls_pkg::REG_RESTRICT_ENABLE: restrict_ff <= csr_wdata[0];
               dls_pkg::REG_TARGET_INDEX:    target_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      e_ff        <= e_in;
      first_ff    <= first_in;
      open_ff     <= open_in;
      row_ff      <= row_in;
      set_ff      <= set_in;
      excluded_ff <= excluded_in;
      depth_ff    <= depth_in;
      if (cmd.emit_load) begin
         rsp_index_ff  <= dls_pkg::TASK_IDX_W'(e_ff);
         rsp_status_ff <= status_now;
         rsp_level_ff  <= level_now;
         rsp_keys_ff   <= dls_pkg::MASK_W'(unres_rdata);
         rsp_last_ff   <= stat.last_emit;
      end
   end

   // Dependency rows and levels
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_TASKS; k++) begin
            rows_ff[k]  <= '0;
            level_ff[k] <= '0;
         end
      end else begin
         if (cmd.scan && stat.row_end) begin
            rows_ff[i_ff]  <= row_next & ~(ONE << i_ff);
            level_ff[i_ff] <= '0;
         end
         if (cmd.peel) begin
            for (int k = 0; k < MAX_TASKS; k++) begin
               if (roots[k]) begin
                  level_ff[k] <= depth_ff;
               end
            end
         end
      end
   end

   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_task_index      = rsp_index_ff;
   assign rsp_task_status     = rsp_status_ff;
   assign rsp_task_level      = rsp_level_ff;
   assign rsp_unresolved_keys = rsp_keys_ff;
   assign rsp_last_result     = rsp_last_ff;

endmodule

// File: design/dependency_level_scheduler.sv
// Dependency level scheduler.
// Request channel (req_*): one task descriptor per word, a needed-key mask and a
// provided-key mask; tasks take indexes 0, 1, ... in arrival order. Descriptors
// are taken one per cycle while the block is idle; a descriptor beyond MAX_TASKS
// is dropped. The word with req_last_task set starts the run, and req_stall stays
// high until the run has handed all its results to the output register.
// Config channel (csr_*): index 0 restrict_enable, index 1 target_index; always
// ready; the user must write it between runs, the block does not enforce this.
// Result channel (rsp_*): one word per loaded task in index order, rsp_last_result
// on the final one. A stalled result holds in the output register; the block waits
// until it is taken.
// A run first builds the rows (one provider read from the descriptor RAM per cycle,
// plus a needed-key read at the start of each row), then repeats the closure step
// until it is stable, peels levels until no roots remain, and for each result
// reads the unresolved-key RAM and then loads the output register.
// Reset (synchronous) clears the task count, configuration, rows, levels and the
// output valid flag; the descriptor RAMs keep old contents, which are never read
// before they are rewritten.
module dependency_level_scheduler #(
   parameter int MAX_TASKS = dls_pkg::MAX_TASKS_DEF,
   parameter int KEY_BITS  = dls_pkg::KEY_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [dls_pkg::MASK_W-1:0]        req_need_mask,
   input  logic [dls_pkg::MASK_W-1:0]        req_provide_mask,
   input  logic                              req_last_task,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [dls_pkg::TASK_IDX_W-1:0]    rsp_task_index,
   output logic [dls_pkg::STATUS_W-1:0]      rsp_task_status,
   output logic [dls_pkg::LEVEL_W-1:0]       rsp_task_level,
   output logic [dls_pkg::MASK_W-1:0]        rsp_unresolved_keys,
   output logic                              rsp_last_result,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dls_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dls_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   dls_pkg::cmd_type  cmd;
   dls_pkg::stat_type stat;

   dls_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_task (req_last_task),
      .req_stall     (req_stall),
      .stat          (stat),
      .cmd           (cmd)
   );

   dls_datapath #(
      .MAX_TASKS (MAX_TASKS),
      .KEY_BITS  (KEY_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_need_mask       (req_need_mask),
      .req_provide_mask    (req_provide_mask),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_task_index      (rsp_task_index),
      .rsp_task_status     (rsp_task_status),
      .rsp_task_level      (rsp_task_level),
      .rsp_unresolved_keys (rsp_unresolved_keys),
      .rsp_last_result     (rsp_last_result)
   );

endmodule

// File: design/dls_checker.sv
module dls_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [dls_pkg::TASK_IDX_W-1:0] rsp_task_index,
   input logic [dls_pkg::STATUS_W-1:0]   rsp_task_status,
   input logic [dls_pkg::LEVEL_W-1:0]    rsp_task_level,
   input logic [dls_pkg::MASK_W-1:0]     rsp_unresolved_keys,
   input logic                           rsp_last_result
);

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_task_index)
         && $stable(rsp_task_status) && $stable(rsp_task_level)
         && $stable(rsp_unresolved_keys) && $stable(rsp_last_result))
      else $error("stalled result word changed");

   // Drop any pending result on reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Only the three status codes leave the block
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_task_status == dls_pkg::STATUS_SCHEDULED)
         || (rsp_task_status == dls_pkg::STATUS_EXCLUDED)
         || (rsp_task_status == dls_pkg::STATUS_CYCLE))
      else $error("bad task status");

   // Level is zero unless the task was scheduled
   a_level_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_task_status != dls_pkg::STATUS_SCHEDULED) |-> rsp_task_level == '0)
      else $error("level on unscheduled task");

endmodule

bind dependency_level_scheduler dls_checker u_dls_checker (.*);
